[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/lla_pkg.sv]
// shared types and fixed field widths for the least-loaded assigner
// no dependencies
package lla_pkg;

   // fixed widths of the transaction fields
   localparam int JOB_W           = 16;
   localparam int BIN_INDEX_W     = 4;
   localparam int BIN_LOAD_W      = 32;
   localparam int BIN_COUNT_W     = 5;
   localparam int BIN_COUNT_RESET = 16;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic clear;   // zero the load
      logic write;   // selected cell takes the new load
   } lla_ctl_type;

endpackage

[rtl/lla_cell.sv]
// one bin of the assigner: holds its load and one stage of the minimum scan
// depends on lla_pkg for the control struct
module lla_cell #(
   parameter int LOAD_WIDTH = 32,
   parameter int IDX_W      = 4,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lla_pkg::lla_ctl_type   ctl,
   input  logic                   in_use,
   input  logic [IDX_W-1:0]       sel,
   input  logic [LOAD_WIDTH-1:0]  value,
   input  logic [LOAD_WIDTH-1:0]  prev_load,
   input  logic [IDX_W-1:0]       prev_idx,
   output logic [LOAD_WIDTH-1:0]  next_load,
   output logic [IDX_W-1:0]       next_idx
);
   import lla_pkg::*;

   logic [LOAD_WIDTH-1:0] load_ff, load_in;
   logic [LOAD_WIDTH-1:0] tok_load_ff, tok_load_in;
   logic [IDX_W-1:0]      tok_idx_ff, tok_idx_in;
   logic                  take;

   // load update: clear on a new set, write when this bin was chosen
   always_comb begin
      load_in = load_ff;
      if (ctl.clear) begin
         load_in = '0;
      end else if (ctl.write && (sel == IDX_W'(INDEX))) begin
         load_in = value;
      end
   end

   // scan stage: strictly smaller load wins, so ties keep the lower index
   assign take        = in_use && (load_ff < prev_load);
   assign tok_load_in = take ? load_ff : prev_load;
   assign tok_idx_in  = take ? IDX_W'(INDEX) : prev_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   // token handed to the next cell
   always_ff @(posedge clock) begin
      tok_load_ff <= tok_load_in;
      tok_idx_ff  <= tok_idx_in;
   end

   assign next_load = tok_load_ff;
   assign next_idx  = tok_idx_ff;

endmodule

[rtl/least_loaded_assigner.sv]
// top level of the least-loaded assigner: sequencer, config register, cell row
// depends on lla_pkg and lla_cell
//
//  channel   handshake                 payload
//  request   start & !busy             req_job_size, req_new_set
//  response  rsp_strobe (one cycle)    rsp_bin_index, rsp_bin_load
//  config    csr_valid & csr_ready     csr_data (bin_count)
//
// a job goes from acceptance through the scan state, while the minimum token
// walks the cell row, and the place state; the response strobe is registered.
// busy is high over that span; a new job may start in the strobe cycle.
// reset is synchronous; loads clear to zero and bin_count returns to 16.
// the response cannot be stalled; csr_ready is low while busy.
module least_loaded_assigner #(
   parameter int MAX_BINS   = 16,
   parameter int LOAD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lla_pkg::JOB_W-1:0]       req_job_size,
   input  logic                            req_new_set,
   output logic                            rsp_strobe,
   output logic [lla_pkg::BIN_INDEX_W-1:0] rsp_bin_index,
   output logic [lla_pkg::BIN_LOAD_W-1:0]  rsp_bin_load,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lla_pkg::BIN_COUNT_W-1:0] csr_data
);
   import lla_pkg::*;

   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int SUM_W = ((LOAD_WIDTH > JOB_W) ? LOAD_WIDTH : JOB_W) + 1;
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_BINS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [JOB_W-1:0]         job_ff;
   logic [BIN_COUNT_W-1:0]   bin_count_ff;
   logic                     rsp_strobe_ff;
   logic [BIN_INDEX_W-1:0]   rsp_bin_index_ff;
   logic [BIN_LOAD_W-1:0]    rsp_bin_load_ff;

   logic                     accept;
   lla_ctl_type              ctl;
   logic [SUM_W-1:0]         sum;
   logic [LOAD_WIDTH-1:0]    sat_load;
   logic [MAX_BINS-1:0]      use_vec;

   logic [LOAD_WIDTH-1:0]    tok_load [0:MAX_BINS];
   logic [IDX_W-1:0]         tok_idx  [0:MAX_BINS];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   // broadcast control: clear at acceptance, write in the place cycle
   assign ctl.clear = accept && req_new_set;
   assign ctl.write = (state_ff == ST_PLACE);

   // saturating add on the winning load from the end of the row
   assign sum      = SUM_W'(tok_load[MAX_BINS]) + SUM_W'(job_ff);
   assign sat_load = (sum > SUM_W'({LOAD_WIDTH{1'b1}})) ? {LOAD_WIDTH{1'b1}}
                                                      : LOAD_WIDTH'(sum);

   // token entering the row: worst possible load, bin 0
   assign tok_load[0] = {LOAD_WIDTH{1'b1}};
   assign tok_idx[0]  = '0;

   // cell row
   for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
      // bin 0 is always in use; others below the configured count
      assign use_vec[i] = (i == 0) || (32'(i) < 32'(bin_count_ff));

      lla_cell #(
         .LOAD_WIDTH (LOAD_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_use    (use_vec[i]),
         .sel       (tok_idx[MAX_BINS]),
         .value     (sat_load),
         .prev_load (tok_load[i]),
         .prev_idx  (tok_idx[i]),
         .next_load (tok_load[i+1]),
         .next_idx  (tok_idx[i+1])
      );
   end

   // bin count register
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_W'(BIN_COUNT_RESET);
      end else if (csr_valid && csr_ready) begin
         bin_count_ff <= csr_data;
      end
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  job_ff   <= req_job_size;
                  cnt_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // token passes through the register of each cell to reach the end
               if (cnt_ff == SCAN_LAST) begin
                  state_ff <= ST_PLACE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_PLACE: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_bin_index_ff <= BIN_INDEX_W'(tok_idx[MAX_BINS]);
               rsp_bin_load_ff  <= BIN_LOAD_W'(sat_load);
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_bin_index = rsp_bin_index_ff;
   assign rsp_bin_load  = rsp_bin_load_ff;

endmodule

[rtl/lla_checker.sv]
// port-level checks for the least-loaded assigner, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module lla_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_valid,
   input logic csr_ready
);

   logic accept;
   assign accept = start && !busy;

   // an accepted job keeps the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)

   // a response only closes out a job that was in flight
   `ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_strobe, $past(busy) && !busy)

   // the strobe lasts one cycle per transaction
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)

   // every job that finishes yields its response
   `ASSERT_IMPLY(a_done_rsp, clock, reset, $fell(busy) && !$past(reset), rsp_strobe)

   // config is not taken while a job runs
   `ASSERT_IMPLY(a_csr_idle, clock, reset, csr_valid && csr_ready, !busy)

endmodule

bind least_loaded_assigner lla_checker u_lla_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
